[design/wcs_pkg.sv]
// ----------------------------------------------------------------------------
// Watering cycle sequencer package
// Shared types and constants for the watering cycle sequencer.
// ----------------------------------------------------------------------------
package wcs_pkg;

  typedef enum logic [2:0] {
    ST_WAIT         = 3'd0,
    ST_INTERVAL     = 3'd1,
    ST_DRAIN_BEFORE = 3'd2,
    ST_OXYGEN       = 3'd3,
    ST_WATERING     = 3'd4,
    ST_DRAIN_AFTER  = 3'd5,
    ST_LIGHTS       = 3'd6,
    ST_SERVICE      = 3'd7
  } cycle_state_e;

  typedef enum logic [1:0] {
    CFG_WATERING_INTERVAL   = 2'd0,
    CFG_WATERINGS_PER_DRAIN = 2'd1,
    CFG_OXYGEN_INTERVAL     = 2'd2,
    CFG_WATERING_DURATION   = 2'd3
  } cfg_index_e;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned GramsW   = 16;
  localparam int unsigned TicksW   = 16;
  localparam int unsigned PassW    = 7;
  localparam int unsigned DeltaW   = 17;
  localparam int unsigned SumW     = 24;

  localparam logic [TicksW-1:0] TicksMax          = 16'hFFFF;
  localparam logic [TicksW-1:0] WaitTicks         = 16'd60;
  localparam logic [TicksW-1:0] DrainTimeoutTicks = 16'd240;
  localparam logic [GramsW-1:0] DrainFullGrams    = 16'd5000;
  localparam logic [GramsW-1:0] WaterLowGrams     = 16'd2000;
  localparam logic signed [SumW-1:0] EmptySumLimit = -24'sd5;

  localparam logic [TicksW-1:0] RstWateringInterval = 16'd3600;
  localparam logic [PassW-1:0]  RstWateringsPerDrain = 7'd1;
  localparam logic [TicksW-1:0] RstOxygenInterval   = 16'd60;
  localparam logic [TicksW-1:0] RstWateringDuration = 16'd240;

  typedef struct packed {
    logic drain;
    logic oxygen;
    logic pressure;
  } pumps_t;

  typedef struct packed {
    logic [2:0] cycle_state;
    pumps_t     pumps;
    logic       service_led;
    logic       lights_update;
    logic       watering_started;
    logic       tank_empty;
  } result_t;

endpackage

[design/watering_cycle_sequencer_top.sv]
// ----------------------------------------------------------------------------
// Watering cycle sequencer
// Tick-driven watering cycle controller with a windowed tank weight trend.
// ----------------------------------------------------------------------------
// Each accepted tick carries the tank weight and a service request and yields
// one result with the cycle state, pump levels, service LED and strobes. The
// block takes one tick per clock cycle while in_stall_o is low. The recent
// weight deltas live in a small synchronous memory whose next entry is read
// ahead into a register, so a tick's read-modify-write never waits on it.
// A two-entry output buffer lets input transfers continue while one result
// waits; the input stalls only when both entries are full.
module watering_cycle_sequencer_top #(
  parameter int unsigned WINDOW_LEN = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  wcs_pkg::cfg_index_e cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] tank_grams_i,
  input  logic        service_request_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  cycle_state_o,
  output logic        drain_pump_on_o,
  output logic        oxygen_pump_on_o,
  output logic        pressure_pump_on_o,
  output logic        service_led_o,
  output logic        lights_update_o,
  output logic        watering_started_o,
  output logic        tank_empty_o
);
  import wcs_pkg::*;

  localparam int unsigned PosW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam logic [PosW-1:0]   PosLast   = PosW'(WINDOW_LEN - 1);
  localparam logic [TicksW-1:0] WinTicks  = TicksW'(WINDOW_LEN);
  localparam logic signed [SumW-1:0] DrainSumLimit = SumW'(5 * WINDOW_LEN);

  // Configuration registers.
  logic [TicksW-1:0] watering_interval_q, oxygen_interval_q, watering_duration_q;
  logic [PassW-1:0]  waterings_per_drain_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      watering_interval_q   <= RstWateringInterval;
      waterings_per_drain_q <= RstWateringsPerDrain;
      oxygen_interval_q     <= RstOxygenInterval;
      watering_duration_q   <= RstWateringDuration;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_WATERING_INTERVAL:   watering_interval_q   <= cfg_data_i;
        CFG_WATERINGS_PER_DRAIN: waterings_per_drain_q <= cfg_data_i[PassW-1:0];
        CFG_OXYGEN_INTERVAL:     oxygen_interval_q     <= cfg_data_i;
        CFG_WATERING_DURATION:   watering_duration_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake and output buffer.
  logic    accept;
  logic    out_fire;
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q, res_d;

  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_fire    = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign cycle_state_o      = out_q.cycle_state;
  assign drain_pump_on_o    = out_q.pumps.drain;
  assign oxygen_pump_on_o   = out_q.pumps.oxygen;
  assign pressure_pump_on_o = out_q.pumps.pressure;
  assign service_led_o      = out_q.service_led;
  assign lights_update_o    = out_q.lights_update;
  assign watering_started_o = out_q.watering_started;
  assign tank_empty_o       = out_q.tank_empty;

  // Sequencer state.
  cycle_state_e      state_q, saved_q;
  logic [TicksW-1:0] elapsed_q;
  logic              parity_q;
  logic [GramsW-1:0] prev_grams_q;
  logic signed [SumW-1:0] sum_q;
  logic [PassW-1:0]  pass_q;
  pumps_t            pumps_q;
  logic              led_q;

  // Delta window memory with a registered read-ahead of the next slot.
  logic [DeltaW-1:0]    win_mem [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] win_valid_q;
  logic [DeltaW-1:0]    rd_data_q;
  logic                 rd_valid_q;
  logic [PosW-1:0]      pos_q, pos_next, rd_addr;

  assign pos_next = (pos_q == PosLast) ? '0 : pos_q + PosW'(1);
  assign rd_addr  = accept ? pos_next : pos_q;

  logic signed [DeltaW-1:0] delta;
  assign delta = $signed({1'b0, tank_grams_i} - {1'b0, prev_grams_q});

  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_mem[pos_q] <= delta;
    end
    rd_data_q <= win_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_valid_q <= '0;
      rd_valid_q  <= 1'b0;
      pos_q       <= '0;
    end else begin
      rd_valid_q <= win_valid_q[rd_addr];
      if (accept) begin
        win_valid_q[pos_q] <= 1'b1;
        pos_q              <= pos_next;
      end
    end
  end

  logic [TicksW-1:0] elapsed_inc;
  logic              parity_d;
  logic signed [SumW-1:0] sum_d;
  logic [DeltaW-1:0] old_delta;

  assign elapsed_inc = (elapsed_q < TicksMax) ? elapsed_q + TicksW'(1) : elapsed_q;
  assign parity_d    = ~parity_q;
  assign old_delta   = rd_valid_q ? rd_data_q : '0;
  assign sum_d = sum_q + $signed({{(SumW-DeltaW){delta[DeltaW-1]}}, delta})
                       - $signed({{(SumW-DeltaW){old_delta[DeltaW-1]}}, old_delta});

  // Service toggle.
  cycle_state_e st_svc, saved_d;
  pumps_t       pumps_svc;
  logic         led_svc;

  always_comb begin
    st_svc    = state_q;
    saved_d   = saved_q;
    pumps_svc = pumps_q;
    led_svc   = led_q;
    if (service_request_i) begin
      if (state_q != ST_SERVICE) begin
        saved_d   = state_q;
        pumps_svc = '0;
        led_svc   = 1'b0;
        st_svc    = ST_SERVICE;
      end else begin
        st_svc  = saved_q;
        led_svc = 1'b1;
      end
    end
  end

  // End conditions.
  logic             drain_done, water_timeout, water_empty, water_done, to_drain;
  logic [PassW-1:0] pass_eff;
  logic [PassW:0]   pass_inc;

  assign drain_done = (elapsed_inc >= DrainTimeoutTicks) ||
                      ((elapsed_inc >= WinTicks) && (prev_grams_q >= DrainFullGrams) &&
                       (sum_d < DrainSumLimit));
  assign water_timeout = elapsed_inc >= watering_duration_q;
  assign water_empty   = !water_timeout && (elapsed_inc >= WinTicks) &&
                         (prev_grams_q <= WaterLowGrams) && (sum_d > EmptySumLimit);
  assign water_done    = water_timeout || water_empty;
  assign pass_eff      = water_empty ? waterings_per_drain_q : pass_q;
  assign pass_inc      = {1'b0, pass_eff} + (PassW+1)'(1);
  assign to_drain      = pass_inc >= {1'b0, waterings_per_drain_q};

  // Next state.
  cycle_state_e state_d;
  logic         change;

  always_comb begin
    state_d = st_svc;
    change  = 1'b0;
    unique case (st_svc)
      ST_WAIT: begin
        if (elapsed_inc >= WaitTicks) begin
          state_d = ST_DRAIN_BEFORE;
          change  = 1'b1;
        end
      end
      ST_INTERVAL: begin
        if (elapsed_inc >= watering_interval_q) begin
          change = 1'b1;
          if (waterings_per_drain_q > PassW'(1)) begin
            state_d = (pass_q == '0) ? ST_OXYGEN : ST_WATERING;
          end else begin
            state_d = ST_DRAIN_BEFORE;
          end
        end
      end
      ST_DRAIN_BEFORE: begin
        if (drain_done) begin
          state_d = ST_OXYGEN;
          change  = 1'b1;
        end
      end
      ST_OXYGEN: begin
        if (elapsed_inc >= oxygen_interval_q) begin
          state_d = ST_WATERING;
          change  = 1'b1;
        end
      end
      ST_WATERING: begin
        if (water_done) begin
          state_d = to_drain ? ST_DRAIN_AFTER : ST_LIGHTS;
          change  = 1'b1;
        end
      end
      ST_DRAIN_AFTER: begin
        if (drain_done) begin
          state_d = ST_LIGHTS;
          change  = 1'b1;
        end
      end
      ST_LIGHTS: begin
        state_d = ST_INTERVAL;
        change  = 1'b1;
      end
      ST_SERVICE: ;
      default: ;
    endcase
  end

  // Pumps, strobes and counters.
  pumps_t            pumps_d;
  logic              led_d, lights, started;
  logic [PassW-1:0]  pass_d;
  logic [TicksW-1:0] elapsed_d;

  always_comb begin
    pumps_d = pumps_svc;
    led_d   = led_svc;
    lights  = 1'b0;
    started = 1'b0;
    pass_d  = pass_q;
    unique case (st_svc)
      ST_WAIT: begin
        if (change) begin
          pumps_d.drain = 1'b1;
        end
      end
      ST_INTERVAL: begin
        if (change) begin
          unique case (state_d)
            ST_OXYGEN:   pumps_d.oxygen   = 1'b1;
            ST_WATERING: pumps_d.pressure = 1'b1;
            default:     pumps_d.drain    = 1'b1;
          endcase
        end
      end
      ST_DRAIN_BEFORE: begin
        if (change) begin
          pumps_d.drain  = 1'b0;
          pumps_d.oxygen = 1'b1;
        end
      end
      ST_OXYGEN: begin
        if (change) begin
          started          = 1'b1;
          pumps_d.oxygen   = 1'b0;
          pumps_d.pressure = 1'b1;
        end
      end
      ST_WATERING: begin
        if (change) begin
          pumps_d.pressure = 1'b0;
          if (to_drain) begin
            pumps_d.drain = 1'b1;
            pass_d        = '0;
          end else begin
            pass_d = pass_inc[PassW-1:0];
          end
        end
      end
      ST_DRAIN_AFTER: begin
        if (change) begin
          pumps_d.drain = 1'b0;
        end
      end
      ST_LIGHTS: begin
        lights = 1'b1;
      end
      ST_SERVICE: begin
        led_d = parity_d;
      end
      default: ;
    endcase
    elapsed_d = change ? '0 : elapsed_inc;
  end

  always_comb begin
    res_d.cycle_state      = state_d;
    res_d.pumps            = pumps_d;
    res_d.service_led      = led_d;
    res_d.lights_update    = lights;
    res_d.watering_started = started;
    res_d.tank_empty       = (st_svc == ST_WATERING) && water_empty;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_WAIT;
      saved_q      <= ST_WAIT;
      elapsed_q    <= '0;
      parity_q     <= 1'b0;
      prev_grams_q <= '0;
      sum_q        <= '0;
      pass_q       <= '0;
      pumps_q      <= '0;
      led_q        <= 1'b0;
    end else if (accept) begin
      state_q      <= state_d;
      saved_q      <= saved_d;
      elapsed_q    <= elapsed_d;
      parity_q     <= parity_d;
      prev_grams_q <= tank_grams_i;
      sum_q        <= sum_d;
      pass_q       <= pass_d;
      pumps_q      <= pumps_d;
      led_q        <= led_d;
    end
  end

endmodule
